/* rtl/udc_pkg.sv */
// ----------------------------------------------------------------------------
// udc_pkg: shared types and constants for the up/down counter display
// Holds the hex seven-segment font, the digit enable codes and the button
// control bundle that runs between the top level and the debounce units.
// ----------------------------------------------------------------------------
package udc_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned SegW   = 8;
  localparam int unsigned DigW   = 3;
  localparam int unsigned LedW   = 2;

  localparam logic [7:0] DebounceReset = 8'd20;

  // One-hot digit enables, and all zero for off
  localparam logic [DigW-1:0] DigOff   = 3'b000;
  localparam logic [DigW-1:0] DigCount = 3'b001;
  localparam logic [DigW-1:0] DigLow   = 3'b010;
  localparam logic [DigW-1:0] DigHigh  = 3'b100;

  // Per-item control for one button's debounce unit
  typedef struct packed {
    logic step;     // an item is accepted this cycle
    logic pressed;  // button level is low
    logic tick;     // millisecond tick in this item
  } btn_ctrl_t;

  // Hex digit to seven-segment pattern (gfedcba, active high)
  function automatic logic [SegW-1:0] hex_seg(input logic [3:0] nib);
    logic [SegW-1:0] seg;
    case (nib)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h6F;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      4'hF: seg = 8'h71;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

/* rtl/updown_counter_hex_display_alarm.sv */
// ----------------------------------------------------------------------------
// updown_counter_hex_display_alarm: debounced up/down counter with display
// One item is taken per clock and its result is ready the next cycle; a new
// item may enter every cycle while the consumer keeps taking results, since
// the state registers themselves form the result register and the input
// side stalls only while an untaken result is held. Two active-low buttons
// step an 8-bit wrapping count after a debounce of debounce_ticks ms ticks
// (0 acts as 1), the ADC sample is held on adc_valid, a refresh tick steps
// the three-phase display, and alarm is high while the held sample exceeds
// the count. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module updown_counter_hex_display_alarm (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        ms_tick_i,
  input  logic        inc_button_level_i,
  input  logic        dec_button_level_i,
  input  logic        adc_valid_i,
  input  logic [7:0]  adc_sample_i,
  input  logic        refresh_tick_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  segments_o,
  output logic [2:0]  digit_enable_o,
  output logic [1:0]  leds_o,
  output logic        alarm_o,
  output logic [7:0]  count_value_o
);

  logic               step;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         debounce_q;
  logic [7:0]         count_q, count_d;
  logic [7:0]         adc_q, adc_d;
  logic               alarm_q;
  logic               inc_confirm, dec_confirm;
  udc_pkg::btn_ctrl_t inc_ctrl, dec_ctrl;

  // Handshake: stall only while a result waits
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Debounce register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= udc_pkg::DebounceReset;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_data_i;
    end
  end

  // Button debounce units
  assign inc_ctrl = '{step: step, pressed: !inc_button_level_i, tick: ms_tick_i};
  assign dec_ctrl = '{step: step, pressed: !dec_button_level_i, tick: ms_tick_i};

  udc_btn_debounce u_inc (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (inc_ctrl),
    .debounce_ticks_i (debounce_q),
    .confirm_o        (inc_confirm)
  );

  udc_btn_debounce u_dec (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (dec_ctrl),
    .debounce_ticks_i (debounce_q),
    .confirm_o        (dec_confirm)
  );

  // Count and ADC hold; both confirms cancel out
  always_comb begin
    count_d = count_q;
    if (inc_confirm && !dec_confirm) begin
      count_d = count_q + 8'd1;
    end else if (dec_confirm && !inc_confirm) begin
      count_d = count_q - 8'd1;
    end
    adc_d = adc_valid_i ? adc_sample_i : adc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      adc_q       <= '0;
      alarm_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        count_q <= count_d;
        adc_q   <= adc_d;
        alarm_q <= (adc_d > count_d);
      end
    end
  end

  // Display multiplex
  udc_disp_mux u_disp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .refresh_i      (refresh_tick_i),
    .count_i        (count_d),
    .adc_i          (adc_d),
    .segments_o     (segments_o),
    .digit_enable_o (digit_enable_o),
    .leds_o         (leds_o)
  );

  assign out_valid_o   = out_valid_q;
  assign alarm_o       = alarm_q;
  assign count_value_o = count_q;

endmodule

/* rtl/udc_btn_debounce.sv */
// ----------------------------------------------------------------------------
// udc_btn_debounce: arming flag and debounce timer for one button
// A press while armed loads the timer; when ms ticks run it down to zero
// with the button still pressed, a confirm pulse is given and the button
// stays disarmed until it is released.
// ----------------------------------------------------------------------------
module udc_btn_debounce (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  udc_pkg::btn_ctrl_t   ctrl_i,
  input  logic [7:0]           debounce_ticks_i,
  output logic                 confirm_o
);

  logic       armed_q, armed_d;
  logic [7:0] wait_q, wait_d;
  logic [7:0] wait_dec;

  assign wait_dec = wait_q - 8'd1;

  // Timer and arming update for one item
  always_comb begin
    armed_d   = armed_q;
    wait_d    = wait_q;
    confirm_o = 1'b0;
    if (wait_q != 8'd0) begin
      if (ctrl_i.tick) begin
        wait_d = wait_dec;
        if (wait_dec == 8'd0 && ctrl_i.pressed) begin
          armed_d   = 1'b0;
          confirm_o = ctrl_i.step;
        end
      end
    end else if (armed_q && ctrl_i.pressed) begin
      // zero means one tick
      wait_d = (debounce_ticks_i == 8'd0) ? 8'd1 : debounce_ticks_i;
    end else if (!ctrl_i.pressed) begin
      armed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b1;
      wait_q  <= 8'd0;
    end else if (ctrl_i.step) begin
      armed_q <= armed_d;
      wait_q  <= wait_d;
    end
  end

endmodule

/* rtl/udc_disp_mux.sv */
// ----------------------------------------------------------------------------
// udc_disp_mux: three-phase display multiplex
// Each refresh on an accepted item shows, in turn, the raw count (latching
// the LEDs), the low ADC nibble and the high ADC nibble through the hex font.
// ----------------------------------------------------------------------------
module udc_disp_mux (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        refresh_i,
  input  logic [udc_pkg::CountW-1:0]  count_i,
  input  logic [7:0]                  adc_i,
  output logic [udc_pkg::SegW-1:0]    segments_o,
  output logic [udc_pkg::DigW-1:0]    digit_enable_o,
  output logic [udc_pkg::LedW-1:0]    leds_o
);

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_LOW   = 2'd1,
    PH_HIGH  = 2'd2
  } phase_e;

  phase_e                      phase_q;
  logic [udc_pkg::SegW-1:0]    seg_q;
  logic [udc_pkg::DigW-1:0]    en_q;
  logic [udc_pkg::LedW-1:0]    led_q;

  // Phase sequencer with registered display drive
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      seg_q   <= '0;
      en_q    <= udc_pkg::DigOff;
      led_q   <= '0;
    end else if (step_i && refresh_i) begin
      case (phase_q)
        PH_COUNT: begin
          led_q   <= count_i[udc_pkg::LedW-1:0];
          seg_q   <= count_i;
          en_q    <= udc_pkg::DigCount;
          phase_q <= PH_LOW;
        end
        PH_LOW: begin
          seg_q   <= udc_pkg::hex_seg(adc_i[3:0]);
          en_q    <= udc_pkg::DigLow;
          phase_q <= PH_HIGH;
        end
        PH_HIGH: begin
          seg_q   <= udc_pkg::hex_seg(adc_i[7:4]);
          en_q    <= udc_pkg::DigHigh;
          phase_q <= PH_COUNT;
        end
        default: begin
          // unreachable phase: blank and restart
          en_q    <= udc_pkg::DigOff;
          phase_q <= PH_COUNT;
        end
      endcase
    end
  end

  assign segments_o     = seg_q;
  assign digit_enable_o = en_q;
  assign leds_o         = led_q;

endmodule

/* rtl/udc_checker.sv */
// ----------------------------------------------------------------------------
// udc_checker: port-level checks for the up/down counter display
// Watches the top level's ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module udc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [7:0]  segments_o,
  input  logic [2:0]  digit_enable_o,
  input  logic [1:0]  leds_o,
  input  logic        alarm_o,
  input  logic [7:0]  count_value_o
);

  // A held result does not change until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_value_o)
      && $stable(segments_o) && $stable(digit_enable_o) && $stable(alarm_o))
    else $error("result changed while stalled");

  // At most one digit driven
  a_digit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(digit_enable_o))
    else $error("more than one digit enabled");

  // Count moves only by one step, and only after an accepted item
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_value_o) |-> $past(in_valid_i && in_ready_o)
      && (count_value_o == $past(count_value_o) + 8'd1
          || count_value_o == $past(count_value_o) - 8'd1))
    else $error("count jumped");

  // Entering the count digit latches the LEDs from the count shown
  a_led_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_enable_o == 3'b001 && !$stable(digit_enable_o)
      |-> leds_o == count_value_o[1:0])
    else $error("leds do not match count");

endmodule

bind updown_counter_hex_display_alarm udc_checker u_udc_checker (.*);
